// File: rtl/core/sst_pkg.sv
package sst_pkg;

	localparam int SST_DEPTH = 64;

	localparam int ID_W    = 16;
	localparam int SCORE_W = 16;
	localparam int POS_W   = 6;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 7;

	localparam int IN_W  = 40;
	localparam int OUT_W = 48;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY_POS = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
	} entry_t;

	typedef struct packed {
		logic              cap;
		logic              scan_down;
		logic              scan_up;
		logic              scan_issue;
		logic              rd_pos;
		logic              wr_new_up;
		logic              wr_shift_up;
		logic              wr_new_zero;
		logic              wr_shift_down;
		logic              set_found;
		logic              cnt_inc;
		logic              cnt_dec;
		logic              res_clr;
		logic              res_rd;
		logic              st_load;
		logic [STAT_W-1:0] st_code;
		logic              out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             cnt_zero;
		logic             pos_ok;
		logic             rd_v;
		logic             score_ge;
		logic             id_hit;
		logic             idx_zero;
		logic             idx_last;
		logic             found;
		logic             end_scan;
		logic             out_free;
	} dp_stat_t;

endpackage

// File: rtl/core/sst_ctrl.sv
module sst_ctrl import sst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_INS_SCAN,
		S_INS_HEAD,
		S_REM_SCAN,
		S_RD_WAIT,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.res_clr = 1'b1;
				case (stat.cmd)
					CMD_INSERT: begin
						if (stat.full) begin
							cmd.st_load = 1'b1;
							cmd.st_code = ST_FULL;
							state_d     = S_FINISH;
						end else if (stat.cnt_zero) begin
							cmd.wr_new_zero = 1'b1;
							cmd.cnt_inc     = 1'b1;
							cmd.st_load     = 1'b1;
							cmd.st_code     = ST_OK;
							state_d         = S_FINISH;
						end else begin
							cmd.scan_down = 1'b1;
							state_d       = S_INS_SCAN;
						end
					end
					CMD_REMOVE: begin
						if (stat.cnt_zero) begin
							cmd.st_load = 1'b1;
							cmd.st_code = ST_NOT_FOUND;
							state_d     = S_FINISH;
						end else begin
							cmd.scan_up = 1'b1;
							state_d     = S_REM_SCAN;
						end
					end
					CMD_READ: begin
						if (stat.pos_ok) begin
							cmd.rd_pos = 1'b1;
							state_d    = S_RD_WAIT;
						end else begin
							cmd.st_load = 1'b1;
							cmd.st_code = ST_EMPTY_POS;
							state_d     = S_FINISH;
						end
					end
					default: begin
						cmd.st_load = 1'b1;
						cmd.st_code = ST_OK;
						state_d     = S_FINISH;
					end
				endcase
			end
			S_INS_SCAN: begin
				cmd.scan_issue = !stat.end_scan;
				if (stat.rd_v) begin
					if (stat.score_ge) begin
						cmd.wr_new_up = 1'b1;
						cmd.cnt_inc   = 1'b1;
						cmd.st_load   = 1'b1;
						cmd.st_code   = ST_OK;
						state_d       = S_FINISH;
					end else begin
						cmd.wr_shift_up = 1'b1;
						if (stat.idx_zero) begin
							state_d = S_INS_HEAD;
						end
					end
				end
			end
			S_INS_HEAD: begin
				cmd.wr_new_zero = 1'b1;
				cmd.cnt_inc     = 1'b1;
				cmd.st_load     = 1'b1;
				cmd.st_code     = ST_OK;
				state_d         = S_FINISH;
			end
			S_REM_SCAN: begin
				cmd.scan_issue = !stat.end_scan;
				if (stat.rd_v) begin
					if (stat.found) begin
						cmd.wr_shift_down = 1'b1;
					end else if (stat.id_hit) begin
						cmd.set_found = 1'b1;
					end
					if (stat.idx_last) begin
						cmd.st_load = 1'b1;
						cmd.st_code = (stat.found || stat.id_hit) ? ST_OK : ST_NOT_FOUND;
						cmd.cnt_dec = stat.found || stat.id_hit;
						state_d     = S_FINISH;
					end
				end
			end
			S_RD_WAIT: begin
				cmd.res_rd  = 1'b1;
				cmd.st_load = 1'b1;
				cmd.st_code = ST_OK;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/sst_datapath.sv
module sst_datapath import sst_pkg::*; #(
	parameter int DEPTH = SST_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IN_W-1:0]  in_data,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t mem [DEPTH];

	logic [CMD_W-1:0]   cmd_q;
	logic [ID_W-1:0]    id_q;
	logic [SCORE_W-1:0] score_q;
	logic [POS_W-1:0]   pos_q;

	logic [CW-1:0] count_q;
	logic [AW-1:0] k_q;
	logic          end_q;
	logic          down_q;
	logic          found_q;

	logic          rd_v_s1;
	logic [AW-1:0] idx_s1;
	entry_t        rdata_s1;

	logic [STAT_W-1:0]  st_q;
	logic [ID_W-1:0]    rid_q;
	logic [SCORE_W-1:0] rsc_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	logic [CW-1:0]          cnt_m1;
	logic [AW-1:0]          last_idx;
	logic [AW+POS_W-1:0]    pos_wide;
	logic [CW+CNT_W-1:0]    cnt_wide;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	entry_t                 wr_data;
	entry_t                 new_e;

	assign cnt_m1   = count_q - CW'(1);
	assign last_idx = cnt_m1[AW-1:0];
	assign pos_wide = {{AW{1'b0}}, pos_q};
	assign cnt_wide = {{CNT_W{1'b0}}, count_q};
	assign new_e    = '{id: id_q, score: score_q};

	assign rd_en   = cmd.scan_issue || cmd.rd_pos;
	assign rd_addr = cmd.rd_pos ? pos_wide[AW-1:0] : k_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = new_e;
		if (cmd.wr_new_up) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 + AW'(1);
		end else if (cmd.wr_shift_up) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 + AW'(1);
			wr_data = rdata_s1;
		end else if (cmd.wr_new_zero) begin
			wr_en   = 1'b1;
		end else if (cmd.wr_shift_down) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 - AW'(1);
			wr_data = rdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
			idx_s1   <= rd_addr;
		end
		if (cmd.cap) begin
			cmd_q   <= in_data[1:0];
			id_q    <= in_data[17:2];
			score_q <= in_data[33:18];
			pos_q   <= in_data[39:34];
		end
		if (cmd.res_clr) begin
			rid_q <= '0;
			rsc_q <= '0;
		end else if (cmd.res_rd) begin
			rid_q <= rdata_s1.id;
			rsc_q <= rdata_s1.score;
		end
		if (cmd.st_load) begin
			st_q <= cmd.st_code;
		end
		if (cmd.out_load) begin
			out_data_q <= {{(OUT_W - CNT_W - SCORE_W - ID_W - STAT_W){1'b0}},
				cnt_wide[CNT_W-1:0], rsc_q, rid_q, st_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			k_q         <= '0;
			end_q       <= 1'b1;
			down_q      <= 1'b0;
			found_q     <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= cnt_m1;
			end
			if (cmd.scan_down) begin
				k_q    <= last_idx;
				end_q  <= 1'b0;
				down_q <= 1'b1;
			end else if (cmd.scan_up) begin
				k_q     <= '0;
				end_q   <= 1'b0;
				down_q  <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.scan_issue) begin
				if (down_q) begin
					if (k_q == '0) begin
						end_q <= 1'b1;
					end else begin
						k_q <= k_q - AW'(1);
					end
				end else begin
					if (k_q == last_idx) begin
						end_q <= 1'b1;
					end else begin
						k_q <= k_q + AW'(1);
					end
				end
			end
			if (cmd.set_found) begin
				found_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.cmd      = cmd_q;
		stat.full     = (count_q == CW'(DEPTH));
		stat.cnt_zero = (count_q == '0);
		stat.pos_ok   = ({{CW{1'b0}}, pos_q} < {{POS_W{1'b0}}, count_q});
		stat.rd_v     = rd_v_s1;
		stat.score_ge = (rdata_s1.score >= score_q);
		stat.id_hit   = (rdata_s1.id == id_q);
		stat.idx_zero = (idx_s1 == '0);
		stat.idx_last = (idx_s1 == last_idx);
		stat.found    = found_q;
		stat.end_scan = end_q;
		stat.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/core/sorted_score_table.sv
// Only one item is in work at a time: a new item is accepted only after the result of the
// last one has been loaded into the output register. The table memory scan reads one entry
// and moves one entry per cycle over a single write port.
// Reset: the controller, the entry count and the output valid flag are cleared; the table
// memory is not cleared and holds no valid entries until written.
module sorted_score_table import sst_pkg::*; #(
	parameter int DEPTH = SST_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// cmd[1:0], entry_id[17:2], score[33:18], position[39:34], zero above.
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// status[1:0], read_id[17:2], read_score[33:18], entry_count[40:34], zero above.
	output logic [OUT_W-1:0] m_tdata
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sst_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

// File: tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sst_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [ID_W-1:0]    read_id;
		logic [SCORE_W-1:0] read_score;
		logic [CNT_W-1:0]   entry_count;
	} table_reply_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	// cmd[1:0], entry_id[17:2], score[33:18], position[39:34].
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	// status[1:0], read_id[17:2], read_score[33:18], entry_count[40:34], zero above.
	logic [OUT_W-1:0] m_tdata;

	logic [ID_W-1:0]    table_ids [SST_DEPTH];
	logic [SCORE_W-1:0] table_scores [SST_DEPTH];
	int                 table_count = 0;
	table_reply_t       pending_replies [$];
	int                 mismatches = 0;
	bit                 idle_en = 1'b1;
	bit                 shrinking = 1'b0;
	int                 stall_left = 0;

	sorted_score_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic int gap_length();
		int r;
		if (!idle_en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [ID_W-1:0] rand_id();
		if ($urandom_range(0, 1) == 0)
			return ID_W'($urandom_range(0, 31));
		return ID_W'($urandom);
	endfunction

	function automatic logic [SCORE_W-1:0] rand_score();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '1;
		if (r < 10)
			return '0;
		if (r < 40)
			return SCORE_W'($urandom_range(0, 7) * 9362);
		return SCORE_W'($urandom);
	endfunction

	function automatic logic [POS_W-1:0] rand_position();
		if (table_count > 0 && $urandom_range(0, 9) < 7)
			return POS_W'($urandom_range(0, table_count - 1));
		return POS_W'($urandom_range(0, 63));
	endfunction

	function automatic table_reply_t apply_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
			logic [SCORE_W-1:0] score, logic [POS_W-1:0] pos);
		table_reply_t reply;
		int slot;
		reply = '0;
		slot = 0;
		case (cmd)
			CMD_INSERT: begin
				if (table_count >= SST_DEPTH) begin
					reply.status = ST_FULL;
				end else begin
					while (slot < table_count && table_scores[slot] >= score)
						slot++;
					for (int k = table_count; k > slot; k--) begin
						table_ids[k] = table_ids[k - 1];
						table_scores[k] = table_scores[k - 1];
					end
					table_ids[slot] = id;
					table_scores[slot] = score;
					table_count++;
				end
			end
			CMD_REMOVE: begin
				while (slot < table_count && table_ids[slot] != id)
					slot++;
				if (slot >= table_count) begin
					reply.status = ST_NOT_FOUND;
				end else begin
					for (int k = slot; k + 1 < table_count; k++) begin
						table_ids[k] = table_ids[k + 1];
						table_scores[k] = table_scores[k + 1];
					end
					table_count--;
				end
			end
			CMD_READ: begin
				if (pos < table_count) begin
					reply.read_id = table_ids[pos];
					reply.read_score = table_scores[pos];
				end else begin
					reply.status = ST_EMPTY_POS;
				end
			end
			default: begin
			end
		endcase
		reply.status = reply.status;
		reply.entry_count = CNT_W'(table_count);
		return reply;
	endfunction

	task automatic report_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		table_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				mismatches++;
				$display("%0t ns: reply expected none actual %h", $time, m_tdata);
			end else begin
				want = pending_replies.pop_front();
				report_field("status", want.status, m_tdata[1:0]);
				report_field("read_id", want.read_id, m_tdata[17:2]);
				report_field("read_score", want.read_score, m_tdata[33:18]);
				report_field("entry_count", want.entry_count, m_tdata[40:34]);
				report_field("padding", 0, m_tdata[OUT_W-1:41]);
			end
		end
		if (arst_n && s_tvalid && s_tready)
			pending_replies.push_back(apply_command(s_tdata[1:0], s_tdata[17:2],
				s_tdata[33:18], s_tdata[39:34]));
	end

	// The receiver holds off for a random number of cycles after each cycle of readiness.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			stall_left <= gap_length();
		end
	end

	task automatic send_item(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
			logic [SCORE_W-1:0] score, logic [POS_W-1:0] pos);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {pos, score, id, cmd};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_directed();
		send_item(CMD_INSERT, 16'h0000, 16'h0000, 6'h3F);
		send_item(CMD_INSERT, 16'hFFFF, 16'hFFFF, 6'h00);
		send_item(CMD_INSERT, 16'h1234, 16'hFFFF, 6'h2A);
		send_item(CMD_INSERT, 16'h00FF, 16'h8000, 6'h15);
		for (int p = 0; p < 5; p++)
			send_item(CMD_READ, 16'hA5A5, 16'h5A5A, POS_W'(p));
		send_item(CMD_READ, 16'h0000, 16'h0000, 6'h3F);
		send_item(CMD_REMOVE, 16'hBEEF, 16'hFFFF, 6'h3F);
		send_item(CMD_REMOVE, 16'hFFFF, 16'h0000, 6'h00);
		send_item(CMD_READ, 16'hFFFF, 16'hFFFF, 6'h00);
		send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 6'h3F);
		send_item(CMD_REMOVE, 16'h0000, 16'h1111, 6'h01);
		send_item(CMD_REMOVE, 16'h1234, 16'h2222, 6'h02);
		send_item(CMD_REMOVE, 16'h00FF, 16'h3333, 6'h03);
		send_item(CMD_REMOVE, 16'h0000, 16'h0000, 6'h00);
		send_item(CMD_READ, 16'h0000, 16'h0000, 6'h00);
	endtask

	task automatic test_fill_and_overflow();
		while (table_count < SST_DEPTH)
			send_item(CMD_INSERT, rand_id(), rand_score(), POS_W'($urandom));
		repeat (2)
			send_item(CMD_INSERT, rand_id(), rand_score(), POS_W'($urandom));
		send_item(CMD_READ, rand_id(), rand_score(), 6'h00);
		send_item(CMD_READ, rand_id(), rand_score(), 6'h3F);
		while (table_count > 0)
			send_item(CMD_REMOVE, table_ids[$urandom_range(0, table_count - 1)], rand_score(),
				POS_W'($urandom));
	endtask

	task automatic test_random_mix(int items);
		int r;
		logic [CMD_W-1:0] cmd;
		logic [ID_W-1:0] id;
		repeat (items) begin
			if (table_count == SST_DEPTH && $urandom_range(0, 3) == 0)
				shrinking = 1'b1;
			else if (table_count == 0 && $urandom_range(0, 3) == 0)
				shrinking = 1'b0;
			r = $urandom_range(0, 99);
			if (r < 5)
				cmd = CMD_UNUSED;
			else if (r < 30)
				cmd = CMD_READ;
			else if (r < (shrinking ? 50 : 80))
				cmd = CMD_INSERT;
			else
				cmd = CMD_REMOVE;
			if (cmd == CMD_REMOVE && table_count > 0 && $urandom_range(0, 9) < 8)
				id = table_ids[$urandom_range(0, table_count - 1)];
			else
				id = rand_id();
			send_item(cmd, id, rand_score(), rand_position());
		end
	endtask

	task automatic test_unpaced(int items);
		idle_en = 1'b0;
		test_random_mix(items);
		idle_en = 1'b1;
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_fill_and_overflow();
		test_random_mix(600);
		test_unpaced(200);
		test_random_mix(450);
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("sorted_score_table verification clean");
		else
			$display("sorted_score_table verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("sorted_score_table verification failed");
		$finish;
	end

endmodule
